// ----- design/ied_pkg.sv -----
// ----------------------------------------------------------------------------
// ied_pkg
// Shared widths, constants and inter-stage types of the distance pipeline.
// ----------------------------------------------------------------------------
package ied_pkg;

    localparam int COORD_BITS   = 11;
    localparam int EST_W        = COORD_BITS + 1;
    localparam int K_W          = 2 * COORD_BITS + 1;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int Q_W          = COORD_BITS + 1;
    localparam int NEWTON_STEPS = 4;
    localparam int DIST_W       = 12;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam int IN_W         = 4 * COORD_BITS;
    localparam int S_TDATA_W    = ((IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((DIST_W + 7) / 8) * 8;

    typedef struct packed {
        logic             valid;
        logic [K_W-1:0]   k;
        logic [EST_W-1:0] est;
    } nstage_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
    } res_t;

endpackage

// ----- design/ied_front.sv -----
// ----------------------------------------------------------------------------
// ied_front
// Three stages: absolute differences, squares and first estimate, sum of
// squares.
// ----------------------------------------------------------------------------
module ied_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ied_pkg::COORD_BITS-1:0] first_x,
    input  logic [ied_pkg::COORD_BITS-1:0] first_y,
    input  logic [ied_pkg::COORD_BITS-1:0] second_x,
    input  logic [ied_pkg::COORD_BITS-1:0] second_y,
    output ied_pkg::nstage_t              out
);

    logic                           v1_reg, v2_reg, v3_reg;
    logic [ied_pkg::COORD_BITS-1:0] du_reg, dv_reg;
    logic [ied_pkg::SQ_W-1:0]       squ_reg, sqv_reg;
    logic [ied_pkg::EST_W-1:0]      est2_reg, est3_reg;
    logic [ied_pkg::K_W-1:0]        k_reg;

    logic [ied_pkg::COORD_BITS-1:0] du_next, dv_next;

    always_comb begin
        du_next = (first_x >= second_x) ? first_x - second_x : second_x - first_x;
        dv_next = (first_y >= second_y) ? first_y - second_y : second_y - first_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            du_reg   <= du_next;
            dv_reg   <= dv_next;
            squ_reg  <= ied_pkg::SQ_W'(du_reg) * ied_pkg::SQ_W'(du_reg);
            sqv_reg  <= ied_pkg::SQ_W'(dv_reg) * ied_pkg::SQ_W'(dv_reg);
            est2_reg <= ied_pkg::EST_W'(du_reg) + ied_pkg::EST_W'(dv_reg);
            k_reg    <= ied_pkg::K_W'(squ_reg) + ied_pkg::K_W'(sqv_reg);
            est3_reg <= est2_reg;
        end
    end

    assign out.valid = v3_reg;
    assign out.k     = k_reg;
    assign out.est   = est3_reg;

    // coincident points give both a zero square sum and a zero estimate
    a_zero_est: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && k_reg == '0) |-> (est3_reg == '0))
        else $error("zero distance with non-zero estimate");

endmodule

// ----- design/ied_newton.sv -----
// ----------------------------------------------------------------------------
// ied_newton
// One Newton step: a restoring divider with one quotient bit per stage,
// then the add and halve stage.
// ----------------------------------------------------------------------------
module ied_newton (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  ied_pkg::nstage_t in,
    output ied_pkg::nstage_t out
);

    localparam int QN = ied_pkg::Q_W;
    localparam int EW = ied_pkg::EST_W;

    logic                    v_reg [QN];
    logic [ied_pkg::K_W-1:0] k_reg [QN];
    logic [EW-1:0]           d_reg [QN];
    logic [EW-1:0]           r_reg [QN];
    logic [QN-1:0]           q_reg [QN];

    genvar j;
    generate
        for (j = 0; j < QN; j++) begin : g_div
            logic                    v_prev;
            logic [ied_pkg::K_W-1:0] k_prev;
            logic [EW-1:0]           d_prev;
            logic [EW-1:0]           r_prev;
            logic [QN-1:0]           q_prev;
            logic [EW:0]             rs;
            logic                    ge;
            logic [EW-1:0]           r_next;
            logic [QN-1:0]           q_next;

            if (j == 0) begin : g_first
                assign v_prev = in.valid;
                assign k_prev = in.k;
                assign d_prev = in.est;
                assign r_prev = EW'(in.k >> QN);
                assign q_prev = '0;
            end else begin : g_rest
                assign v_prev = v_reg[j-1];
                assign k_prev = k_reg[j-1];
                assign d_prev = d_reg[j-1];
                assign r_prev = r_reg[j-1];
                assign q_prev = q_reg[j-1];
            end

            always_comb begin
                rs     = {r_prev, k_prev[QN-1-j]};
                ge     = rs >= {1'b0, d_prev};
                r_next = ge ? EW'(rs - {1'b0, d_prev}) : EW'(rs);
                q_next = {q_prev[QN-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (en) begin
                    v_reg[j] <= v_prev;
                    k_reg[j] <= k_prev;
                    d_reg[j] <= d_prev;
                    r_reg[j] <= r_next;
                    q_reg[j] <= q_next;
                end
            end
        end
    endgenerate

    logic                    v_out_reg;
    logic [ied_pkg::K_W-1:0] k_out_reg;
    logic [EW-1:0]           est_out_reg;
    logic [QN-1:0]           q_use;
    logic [EW:0]             sum;

    always_comb begin
        // zero divisor: quotient taken as zero
        q_use = (d_reg[QN-1] == '0) ? '0 : q_reg[QN-1];
        sum   = {1'b0, d_reg[QN-1]} + (EW+1)'(q_use);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg   <= v_reg[QN-1];
            k_out_reg   <= k_reg[QN-1];
            est_out_reg <= EW'(sum >> 1);
        end
    end

    assign out.valid = v_out_reg;
    assign out.k     = k_out_reg;
    assign out.est   = est_out_reg;

    // estimate never collapses to zero while the square sum is non-zero
    a_est_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_out_reg && k_out_reg != '0) |-> (est_out_reg != '0))
        else $error("newton estimate fell to zero");

endmodule

// ----- design/ied_final.sv -----
// ----------------------------------------------------------------------------
// ied_final
// Squares the last estimate, rounds up where it still falls short, and
// saturates to the result width.
// ----------------------------------------------------------------------------
module ied_final (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  ied_pkg::nstage_t in,
    output ied_pkg::res_t    out
);

    localparam int EW = ied_pkg::EST_W;

    logic                    va_reg, vb_reg;
    logic [2*EW-1:0]         sq_reg;
    logic [ied_pkg::K_W-1:0] k_reg;
    logic [EW-1:0]           est_reg;
    logic [ied_pkg::DIST_W-1:0] dist_reg;

    logic                       lt;
    logic [EW:0]                inc;
    logic [ied_pkg::DIST_W-1:0] dist_next;

    always_comb begin
        lt  = sq_reg < (2*EW)'(k_reg);
        inc = {1'b0, est_reg} + (EW+1)'(lt);
        if (inc > (EW+1)'(ied_pkg::DIST_MAX)) begin
            dist_next = ied_pkg::DIST_MAX;
        end else begin
            dist_next = ied_pkg::DIST_W'(inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg   <= in.valid;
            sq_reg   <= (2*EW)'(in.est) * (2*EW)'(in.est);
            k_reg    <= in.k;
            est_reg  <= in.est;
            vb_reg   <= va_reg;
            dist_reg <= dist_next;
        end
    end

    assign out.valid    = vb_reg;
    assign out.distance = dist_reg;

endmodule

// ----- design/ied_out_buf.sv -----
// ----------------------------------------------------------------------------
// ied_out_buf
// Two-entry output buffer; the pipeline runs while it has room.
// ----------------------------------------------------------------------------
module ied_out_buf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ied_pkg::res_t                 in,
    output logic                          en,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ied_pkg::DIST_W-1:0]    head
);

    logic [1:0]                 count_reg, count_next;
    logic [ied_pkg::DIST_W-1:0] buf0_reg, buf0_next;
    logic [ied_pkg::DIST_W-1:0] buf1_reg, buf1_next;
    logic                       push, pop;

    assign en       = (count_reg != 2'd2);
    assign m_tvalid = (count_reg != 2'd0);
    assign head     = buf0_reg;
    assign push     = en && in.valid;
    assign pop      = m_tvalid && m_tready;

    always_comb begin
        count_next = count_reg;
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        case ({push, pop})
            2'b10: begin
                if (count_reg == 2'd0) begin
                    buf0_next = in.distance;
                end else begin
                    buf1_next = in.distance;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01: begin
                buf0_next  = buf1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11: begin
                buf0_next = in.distance;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            buf0_reg  <= buf0_next;
            buf1_reg  <= buf1_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output buffer overfilled");

    a_full_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !m_tready) |=> (count_reg == 2'd2))
        else $error("full buffer lost an entry without a pop");

endmodule

// ----- design/integer_euclidean_distance_top.sv -----
// requests pass the front, four one-bit-per-stage Newton steps, final, buffer
// throughput: one point pair per cycle while s_tready is high
// s_tready drops only while two finished results wait in the output buffer
// reset: synchronous active-low aresetn clears all stage valid bits
// and empties the output buffer
// ----------------------------------------------------------------------------
// integer_euclidean_distance_top
// Rounded-up integer distance of two points via four pipelined Newton steps.
// ----------------------------------------------------------------------------
module integer_euclidean_distance_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // first_x, first_y, second_x, second_y
    input  logic [ied_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // distance
    output logic [ied_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CB = ied_pkg::COORD_BITS;

    logic                       en;
    ied_pkg::nstage_t           chain [ied_pkg::NEWTON_STEPS+1];
    ied_pkg::res_t              res;
    logic [ied_pkg::DIST_W-1:0] head;

    ied_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid && s_tready),
        .first_x  (s_tdata[CB-1:0]),
        .first_y  (s_tdata[2*CB-1:CB]),
        .second_x (s_tdata[3*CB-1:2*CB]),
        .second_y (s_tdata[4*CB-1:3*CB]),
        .out      (chain[0])
    );

    genvar i;
    generate
        for (i = 0; i < ied_pkg::NEWTON_STEPS; i++) begin : g_step
            ied_newton u_newton (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .in      (chain[i]),
                .out     (chain[i+1])
            );
        end
    endgenerate

    ied_final u_final (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in      (chain[ied_pkg::NEWTON_STEPS]),
        .out     (res)
    );

    ied_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in       (res),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign s_tready = en;
    assign m_tdata  = ied_pkg::M_TDATA_W'(head);

endmodule

// ----- sim/integer_euclidean_distance_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_euclidean_distance_top_test
// Drives point pairs into the distance pipeline with random gaps and output
// stalls. Each returned distance is compared with a table value or with a
// local four-step Newton model, in the order the requests went in.
// ----------------------------------------------------------------------------
module integer_euclidean_distance_top_test;

    typedef logic [ied_pkg::COORD_BITS-1:0] coord_t;
    typedef logic [ied_pkg::DIST_W-1:0]     dist_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        logic   fixed;
        dist_t  want_dist;
    } pair_row_t;

    localparam coord_t CMAX    = coord_t'((1 << ied_pkg::COORD_BITS) - 1);
    localparam coord_t CHALF   = coord_t'(1 << (ied_pkg::COORD_BITS - 1));
    localparam coord_t CHALF_M = coord_t'(CHALF - 1);
    localparam coord_t ALT_HI  = 11'b101_0101_0101;
    localparam coord_t ALT_LO  = 11'b010_1010_1010;
    localparam int     N_ROWS  = 17;
    localparam int     N_RAND  = 1200;

    localparam pair_row_t DIRECTED [0:N_ROWS-1] = '{
        '{11'd0,    11'd0,    11'd0,    11'd0,    1'b1, 12'd0},
        '{CMAX,     CMAX,     CMAX,     CMAX,     1'b1, 12'd0},
        '{11'd0,    11'd0,    CMAX,     CMAX,     1'b1, 12'd2895},
        '{CMAX,     CMAX,     11'd0,    11'd0,    1'b1, 12'd2895},
        '{11'd0,    CMAX,     CMAX,     11'd0,    1'b1, 12'd2895},
        '{11'd0,    11'd0,    CMAX,     11'd0,    1'b1, 12'd2047},
        '{11'd0,    11'd0,    11'd0,    CMAX,     1'b1, 12'd2047},
        '{11'd0,    11'd0,    11'd3,    11'd4,    1'b1, 12'd5},
        '{11'd3,    11'd4,    11'd0,    11'd0,    1'b1, 12'd5},
        '{11'd0,    11'd0,    11'd1,    11'd0,    1'b1, 12'd1},
        '{11'd0,    11'd0,    11'd1,    11'd1,    1'b1, 12'd2},
        '{11'd1000, 11'd1000, 11'd1000, 11'd1001, 1'b1, 12'd1},
        '{11'd5,    11'd5,    11'd6,    11'd7,    1'b0, 12'd0},
        '{CHALF,    CHALF,    CHALF_M,  CHALF_M,  1'b0, 12'd0},
        '{ALT_HI,   ALT_LO,   ALT_LO,   ALT_HI,   1'b0, 12'd0},
        '{CMAX,     11'd0,    11'd0,    11'd1,    1'b0, 12'd0},
        '{11'd100,  11'd200,  11'd103,  11'd196,  1'b0, 12'd0}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    // first_x, first_y, second_x, second_y
    logic [ied_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    // distance
    logic [ied_pkg::M_TDATA_W-1:0] m_tdata;

    dist_t pending_distances[$];
    int    mismatch_count = 0;
    bit    steady = 1'b0;

    integer_euclidean_distance_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic dist_t euclid_distance(input coord_t ax, input coord_t ay,
                                              input coord_t bx, input coord_t by);
        longint unsigned a0, a1, b0, b1, du, dv, k, est, q;
        a0 = ax;
        a1 = ay;
        b0 = bx;
        b1 = by;
        du = (a0 >= b0) ? a0 - b0 : b0 - a0;
        dv = (a1 >= b1) ? a1 - b1 : b1 - a1;
        k = du * du + dv * dv;
        est = 0;
        if (k != 0) begin
            est = du + dv;
            for (int i = 0; i < ied_pkg::NEWTON_STEPS; i++) begin
                q = (est != 0) ? k / est : 0;
                est = (est + q) >> 1;
            end
            if (est * est < k)
                est++;
        end
        if (est > ied_pkg::DIST_MAX)
            est = ied_pkg::DIST_MAX;
        return dist_t'(est);
    endfunction

    function automatic coord_t near_coord(input coord_t c);
        int t;
        t = int'(c) + int'($urandom_range(16)) - 8;
        if (t < 0)
            t = 0;
        if (t > int'(CMAX))
            t = int'(CMAX);
        return coord_t'(t);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic offer_pair(input coord_t ax, input coord_t ay, input coord_t bx,
                              input coord_t by, input logic fixed,
                              input dist_t fixed_dist);
        logic [ied_pkg::S_TDATA_W-1:0] word;
        dist_t expected;
        word = '0;
        word[ied_pkg::IN_W-1:0] = {by, bx, ay, ax};
        expected = fixed ? fixed_dist : euclid_distance(ax, ay, bx, by);
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_distances.push_back(expected);
        while (!steady && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge aclk);
    endtask

    // result checking and output stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_distances.size() == 0) begin
                flag_mismatch($sformatf("unexpected result distance=%0d",
                                        m_tdata[ied_pkg::DIST_W-1:0]));
            end else begin
                dist_t want;
                want = pending_distances.pop_front();
                if (m_tdata[ied_pkg::DIST_W-1:0] !== want)
                    flag_mismatch($sformatf("distance=%0d expected %0d",
                                            m_tdata[ied_pkg::DIST_W-1:0], want));
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 38);
    end

    initial begin
        coord_t ax, ay, bx, by;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++)
            offer_pair(DIRECTED[r].ax, DIRECTED[r].ay, DIRECTED[r].bx, DIRECTED[r].by,
                       DIRECTED[r].fixed, DIRECTED[r].want_dist);
        drain_results();
        @(posedge aclk);

        for (int n = 0; n < N_RAND; n++) begin
            steady = (n >= 500 && n < 700);
            if (n == 900) begin
                drain_results();
                @(posedge aclk);
            end
            ax = coord_t'($urandom);
            ay = coord_t'($urandom);
            case ($urandom_range(9))
                0: begin
                    bx = ax;
                    by = ay;
                end
                1: begin
                    ax = $urandom_range(1) ? CMAX : '0;
                    ay = $urandom_range(1) ? CMAX : '0;
                    bx = $urandom_range(1) ? CMAX : '0;
                    by = $urandom_range(1) ? CMAX : '0;
                end
                2, 3: begin
                    bx = near_coord(ax);
                    by = near_coord(ay);
                end
                default: begin
                    bx = coord_t'($urandom);
                    by = coord_t'($urandom);
                end
            endcase
            offer_pair(ax, ay, bx, by, 1'b0, '0);
        end
        steady = 1'b0;

        drain_results();
        repeat (80) @(posedge aclk);
        if (mismatch_count == 0 && pending_distances.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/ied_pkg.sv
design/ied_front.sv
design/ied_newton.sv
design/ied_final.sv
design/ied_out_buf.sv
design/integer_euclidean_distance_top.sv
sim/integer_euclidean_distance_top_test.sv
